// ===== hdl/multi_column_key_hasher_macros.svh =====
// Assertion macros for the multi-column key hasher.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef MULTI_COLUMN_KEY_HASHER_MACROS_SVH
`define MULTI_COLUMN_KEY_HASHER_MACROS_SVH
`ifndef SYNTHESIS
`define MCKH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MCKH_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MCKH_ASSERT(lbl, prop, msg)
`define MCKH_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hdl/mckh_pkg.sv =====
// Package for the multi-column key hasher: hash constants, microcode types
// and the microcode program. No dependencies.
package mckh_pkg;

	localparam logic [63:0] HashSeed   = 64'h0000_0000_c70f_6907;
	localparam logic [63:0] HashMul    = 64'hc6a4_a793_5bd1_e995;
	localparam logic [63:0] MixGolden  = 64'h9e37_79b9_7f4a_7c15;
	localparam int          HashShift  = 47;
	localparam int          MixLeft    = 12;
	localparam int          MixRight   = 4;

	typedef logic [4:0] pc_t;

	localparam pc_t StepBody = 5'd5;
	localparam pc_t StepFin  = 5'd18;
	localparam pc_t StepTail = 5'd25;
	localparam pc_t ProgLast = 5'd29;

	typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_HL, MUL_LH} mul_op_t;
	typedef enum logic [2:0] {
		X_HOLD, X_LEN, X_WORD, X_PMIX, X_HXORP, X_HFIN, X_FOLD, X_HTAIL
	} xsrc_t;
	typedef enum logic [1:0] {H_HOLD, H_SEED, H_P, H_PMIX} hdst_t;
	typedef enum logic [1:0] {B_HOLD, B_LOAD, B_SUB8, B_CLEAR} bop_t;
	typedef enum logic [1:0] {C_INSIDE, C_PARTIAL, C_NOBYTES, C_MORE} cond_t;
	typedef enum logic [2:0] {J_NEXT, J_IF, J_GO, J_END, J_IF_END} jmp_t;

	typedef struct packed {
		mul_op_t mul;
		xsrc_t   xsrc;
		hdst_t   hdst;
		bop_t    bop;
		logic    set_inside;
		logic    fold;
		jmp_t    jmp;
		cond_t   cond;
		pc_t     target;
	} ctl_t;

	localparam ctl_t CtlNop = '{
		mul: MUL_NONE, xsrc: X_HOLD, hdst: H_HOLD, bop: B_HOLD,
		set_inside: 1'b0, fold: 1'b0, jmp: J_NEXT, cond: C_INSIDE, target: 5'd0
	};

	function automatic ctl_t ucode(pc_t pc);
		ctl_t c;
		c = CtlNop;
		unique case (pc)
			5'd0: begin
				c.xsrc = X_LEN;
				c.jmp = J_IF;
				c.cond = C_INSIDE;
				c.target = StepBody;
			end
			5'd1, 5'd6, 5'd10, 5'd14, 5'd19, 5'd26: c.mul = MUL_LL;
			5'd2, 5'd7, 5'd11, 5'd15, 5'd20, 5'd27: c.mul = MUL_HL;
			5'd3, 5'd8, 5'd12, 5'd16, 5'd21, 5'd28: c.mul = MUL_LH;
			5'd4: begin
				c.hdst = H_SEED;
				c.bop = B_LOAD;
				c.set_inside = 1'b1;
			end
			5'd5: begin
				c.xsrc = X_WORD;
				c.jmp = J_IF;
				c.cond = C_PARTIAL;
				c.target = StepTail;
			end
			5'd9:  c.xsrc = X_PMIX;
			5'd13: c.xsrc = X_HXORP;
			5'd17: begin
				c.hdst = H_P;
				c.bop = B_SUB8;
				c.jmp = J_IF_END;
				c.cond = C_MORE;
			end
			5'd18: c.xsrc = X_HFIN;
			5'd22: c.hdst = H_PMIX;
			5'd23: c.xsrc = X_FOLD;
			5'd24: begin
				c.fold = 1'b1;
				c.jmp = J_END;
			end
			5'd25: begin
				c.xsrc = X_HTAIL;
				c.bop = B_CLEAR;
				c.jmp = J_IF;
				c.cond = C_NOBYTES;
				c.target = StepFin;
			end
			5'd29: begin
				c.hdst = H_P;
				c.jmp = J_GO;
				c.target = StepFin;
			end
			default: c = CtlNop;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/mckh_mul.sv =====
// Shared 64-bit multiply by the hash constant, one 32x32 partial product a step.
// Depends on mckh_pkg for the constant and the step codes.
module mckh_mul (
	input  logic              clk,
	input  mckh_pkg::mul_op_t op,
	input  logic [63:0]       x,
	output logic [63:0]       p
);
	import mckh_pkg::*;

	logic [31:0] a;
	logic [31:0] b;
	logic [63:0] prod;
	logic [63:0] p_q;

	assign a    = (op == MUL_HL) ? x[63:32] : x[31:0];
	assign b    = (op == MUL_LH) ? HashMul[63:32] : HashMul[31:0];
	assign prod = a * b;
	assign p    = p_q;

	always_ff @(posedge clk) begin
		unique case (op)
			MUL_LL:         p_q <= prod;
			MUL_HL, MUL_LH: p_q[63:32] <= p_q[63:32] + prod[31:0];
			MUL_NONE:       p_q <= p_q;
		endcase
	end

endmodule

// ===== hdl/multi_column_key_hasher.sv =====
// Multi-column key hasher top level: microcode sequencer and datapath.
// Depends on mckh_pkg, mckh_mul and multi_column_key_hasher_macros.svh.
//
// channel | dir | tdata (low bit up)                        | tuser | tlast
// s_axis  | in  | key_word[63:0], column_length[71:64]      | -     | last_column
// m_axis  | out | key_hash[63:0]                            | -     | -
//
// One request at a time; ready rises in the cycle after the last microcode step.
// A word that opens a column first hashes its length; a full word is then mixed in,
// a partial or empty word takes the tail path, and a column's end is finished and folded.
// Each 64-bit product is built from three 32x32 partial products on the shared multiplier.
// Reset clears the sequencer, row hash and column state; no clearing pass.
// A finished hash waits in the output register; the next request is taken
// meanwhile, and only its emit step holds while that hash is still pending.
`include "multi_column_key_hasher_macros.svh"

module multi_column_key_hasher #(
	parameter int MAX_COLUMN_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // key_word[63:0], column_length[71:64]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // key_hash[63:0]
);
	import mckh_pkg::*;

	localparam logic [15:0] MaxBytes = 16'(MAX_COLUMN_BYTES);

	logic        busy_q;
	pc_t         pc_q;
	logic        inside_q;
	logic [7:0]  bytes_q;
	logic [63:0] row_q;
	logic [63:0] h_q;
	logic [63:0] x_q;
	logic [63:0] word_q;
	logic [7:0]  len_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;

	ctl_t        ctl;
	logic        cond_ok;
	pc_t         pc_d;
	logic        end_item;
	logic        stall;
	logic        step;
	logic        emit_fire;
	logic [7:0]  in_len;
	logic [7:0]  len_sat;
	logic [63:0] p;
	logic [63:0] tail_mask;
	logic [63:0] row_new;
	mul_op_t     mul_op;

	assign ctl       = ucode(pc_q);
	assign in_len    = s_axis_tdata[71:64];
	assign len_sat   = ({8'd0, in_len} > MaxBytes) ? MaxBytes[7:0] : in_len;
	assign tail_mask = (64'd1 << {bytes_q[2:0], 3'b000}) - 64'd1;
	assign row_new   = row_q ^ (x_q + MixGolden + (row_q >> MixRight));
	assign stall     = ctl.fold && last_q && out_valid_q && !m_axis_tready;
	assign step      = busy_q && !stall;
	assign emit_fire = step && ctl.fold && last_q;
	assign mul_op    = step ? ctl.mul : MUL_NONE;

	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	mckh_mul u_mul (
		.clk (clk),
		.op  (mul_op),
		.x   (x_q),
		.p   (p)
	);

	always_comb begin
		unique case (ctl.cond)
			C_INSIDE:  cond_ok = inside_q;
			C_PARTIAL: cond_ok = bytes_q < 8'd8;
			C_NOBYTES: cond_ok = bytes_q == 8'd0;
			C_MORE:    cond_ok = bytes_q != 8'd8;
		endcase
	end

	always_comb begin
		pc_d = pc_q + 5'd1;
		end_item = 1'b0;
		unique case (ctl.jmp)
			J_NEXT: ;
			J_IF: if (cond_ok) pc_d = ctl.target;
			J_GO: pc_d = ctl.target;
			J_END: end_item = 1'b1;
			J_IF_END: end_item = cond_ok;
			default: end_item = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
			inside_q <= 1'b0;
			bytes_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (s_axis_tvalid) begin
					busy_q <= 1'b1;
					pc_q <= '0;
				end
			end else if (!stall) begin
				pc_q <= pc_d;
				if (end_item) busy_q <= 1'b0;
				if (ctl.set_inside) inside_q <= 1'b1;
				unique case (ctl.bop)
					B_HOLD: ;
					B_LOAD: bytes_q <= len_q;
					B_SUB8: bytes_q <= bytes_q - 8'd8;
					B_CLEAR: bytes_q <= '0;
				endcase
				if (ctl.fold) begin
					inside_q <= 1'b0;
					row_q <= last_q ? '0 : row_new;
				end
			end
			if (emit_fire) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && !busy_q) begin
			word_q <= s_axis_tdata[63:0];
			len_q <= len_sat;
			last_q <= s_axis_tlast;
		end
		if (emit_fire) out_data_q <= row_new;
		if (step) begin
			unique case (ctl.xsrc)
				X_HOLD: ;
				X_LEN: x_q <= {56'd0, len_q};
				X_WORD: x_q <= word_q;
				X_PMIX: x_q <= p ^ (p >> HashShift);
				X_HXORP: x_q <= h_q ^ p;
				X_HFIN: x_q <= h_q ^ (h_q >> HashShift);
				X_FOLD: x_q <= h_q + (row_q << MixLeft);
				X_HTAIL: x_q <= h_q ^ (word_q & tail_mask);
			endcase
			unique case (ctl.hdst)
				H_HOLD: ;
				H_SEED: h_q <= HashSeed ^ p;
				H_P: h_q <= p;
				H_PMIX: h_q <= p ^ (p >> HashShift);
			endcase
		end
	end

	`MCKH_ASSERT(a_accept_starts, (s_axis_tvalid && s_axis_tready) |=> (busy_q && pc_q == '0), "request accepted without starting the program")
	`MCKH_NEVER(a_pc_range, busy_q && (pc_q > ProgLast), "step counter left the program")
	`MCKH_ASSERT(a_emit_clears_row, emit_fire |=> (row_q == '0 && m_axis_tvalid), "row hash not cleared after emit")
	`MCKH_NEVER(a_idle_out_bytes, !busy_q && !inside_q && (bytes_q != 8'd0), "bytes left outside a column")
	`MCKH_NEVER(a_idle_in_bytes, !busy_q && inside_q && (bytes_q == 8'd0), "open column with no bytes left")

endmodule

// ===== verif/tb_multi_column_key_hasher.sv =====
// Testbench for multi_column_key_hasher: streams little-endian key words column by
// column and checks every row hash against a local model of the column hash and row fold.
// Depends only on the RTL of the block.
`timescale 1ns / 100ps

module tb_multi_column_key_hasher;

	localparam int          MAX_COLUMN_BYTES = 255;
	localparam logic [63:0] SEED_BASE        = 64'h0000_0000_c70f_6907;
	localparam logic [63:0] MUL_K            = 64'hc6a4_a793_5bd1_e995;
	localparam logic [63:0] GOLDEN           = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] ALL_ONES         = 64'hffff_ffff_ffff_ffff;
	localparam int          RANDOM_REQS      = 1200;
	localparam int          STEADY_REQS      = 150;
	localparam int          PAUSE_REQ        = 700;
	localparam int          HOLD_AFTER       = 300;
	localparam int          HOLD_CYCLES      = 400;
	localparam int          DRAIN_CYCLES     = 40;
	localparam int          STALL_LIMIT      = 4000;
	localparam int          REPORT_MAX       = 10;

	typedef struct packed {
		logic [63:0] key_word;
		logic [7:0]  column_length;
		logic        last_column;
	} key_req_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata  = '0;  // key_word[63:0], column_length[71:64]
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // key_hash[63:0]

	logic [63:0] col_acc        = '0;
	logic [63:0] row_acc        = '0;
	logic [15:0] col_bytes_left = '0;
	bit          col_open       = 1'b0;

	logic [63:0] pending_hashes[$];
	key_req_t    request_stream[$];
	int          fail_count     = 0;
	int          requests_taken = 0;
	int          stall_cycles   = 0;
	bit          steady_tail    = 1'b0;

	key_req_t directed_reqs [18] = '{
		{64'hffff_ffff_ffff_ffff, 8'd0,   1'b1},
		{64'h0000_0000_0000_0000, 8'd8,   1'b1},
		{64'hffff_ffff_ffff_ffff, 8'd8,   1'b1},
		{64'hffff_ffff_ffff_ffff, 8'd1,   1'b1},
		{64'h0123_4567_89ab_cdef, 8'd7,   1'b1},
		{64'h8000_0000_0000_0001, 8'd0,   1'b0},
		{64'hdead_beef_cafe_f00d, 8'd3,   1'b0},
		{64'h0000_0000_0000_0000, 8'd16,  1'b1},
		{64'hffff_ffff_ffff_ffff, 8'd255, 1'b1},
		{64'ha5a5_a5a5_a5a5_a5a5, 8'd9,   1'b0},
		{64'h5a5a_5a5a_5a5a_5a5a, 8'd0,   1'b0},
		{64'h1111_2222_3333_4444, 8'd5,   1'b1},
		{64'hfedc_ba98_7654_3210, 8'd24,  1'b0},
		{64'h0f0f_0f0f_0f0f_0f0f, 8'd0,   1'b1},
		{64'hf0f0_f0f0_f0f0_f0f0, 8'd255, 1'b1},
		{64'h7fff_ffff_ffff_ffff, 8'd15,  1'b0},
		{64'h8000_0000_0000_0000, 8'd0,   1'b1},
		{64'h0000_0000_0000_0000, 8'd0,   1'b1}
	};

	always #5 clk = ~clk;

	multi_column_key_hasher #(
		.MAX_COLUMN_BYTES(MAX_COLUMN_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	task automatic fold_key_word(input key_req_t req);
		logic [63:0] k;
		logic [63:0] len;
		bit          col_done;
		col_done = 1'b0;
		if (!col_open) begin
			len = {56'd0, req.column_length};
			if (len > 64'(MAX_COLUMN_BYTES))
				len = 64'(MAX_COLUMN_BYTES);
			col_acc = SEED_BASE ^ (len * MUL_K);
			col_bytes_left = len[15:0];
			col_open = 1'b1;
		end
		if (col_bytes_left >= 16'd8) begin
			k = req.key_word * MUL_K;
			k ^= k >> 47;
			k *= MUL_K;
			col_acc = (col_acc ^ k) * MUL_K;
			col_bytes_left -= 16'd8;
			col_done = (col_bytes_left == 16'd0);
		end else begin
			if (col_bytes_left != 16'd0)
				col_acc = (col_acc ^ (req.key_word & ~(ALL_ONES << (8 * col_bytes_left))))
					* MUL_K;
			col_bytes_left = 16'd0;
			col_done = 1'b1;
		end
		if (col_done) begin
			k = col_acc ^ (col_acc >> 47);
			k *= MUL_K;
			k ^= k >> 47;
			row_acc = row_acc ^ (k + GOLDEN + (row_acc << 12) + (row_acc >> 4));
			col_open = 1'b0;
			col_acc = '0;
			if (req.last_column) begin
				pending_hashes = {pending_hashes, row_acc};
				row_acc = '0;
			end
		end
	endtask

	task automatic add_random_key();
		int         n_cols;
		int         n_words;
		int         pick;
		logic [7:0] len;
		key_req_t   req;
		n_cols = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
		for (int c = 0; c < n_cols; c++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				len = 8'd0;
			else if (pick < 14)
				len = 8'(8 * $urandom_range(1, 4));
			else if (pick < 97)
				len = 8'($urandom_range(1, 24));
			else
				len = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(100, 254));
			n_words = (len == 8'd0) ? 1 : (int'(len) + 7) / 8;
			for (int w = 0; w < n_words; w++) begin
				req.key_word = {$urandom, $urandom};
				req.column_length = (w == 0) ? len : 8'($urandom_range(0, 255));
				req.last_column = (w == n_words - 1) ? (c == n_cols - 1)
					: 1'($urandom_range(0, 1));
				request_stream = {request_stream, req};
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		logic [63:0] exp_hash;
		key_req_t    req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_hashes.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected key_hash: actual %h", m_axis_tdata);
				end else begin
					exp_hash = pending_hashes.pop_front();
					if (m_axis_tdata !== exp_hash) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("key_hash mismatch: expected %h, actual %h",
								exp_hash, m_axis_tdata);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.key_word = s_axis_tdata[63:0];
				req.column_length = s_axis_tdata[71:64];
				req.last_column = s_axis_tlast;
				fold_key_word(req);
				requests_taken++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : result_sink
		bit held_long;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_long && requests_taken >= HOLD_AFTER) begin
				held_long = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		key_req_t req;
		int       idx;
		foreach (directed_reqs[i])
			request_stream = {request_stream, directed_reqs[i]};
		while (request_stream.size() < $size(directed_reqs) + RANDOM_REQS)
			add_random_key();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (idx = 0; idx < request_stream.size(); idx++) begin
			req = request_stream[idx];
			if (idx >= request_stream.size() - STEADY_REQS)
				steady_tail = 1'b1;
			// hold off until the block has delivered everything in flight
			if (idx == PAUSE_REQ) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_hashes.size() != 0);
			end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {req.column_length, req.key_word};
			s_axis_tlast <= req.last_column;
			do @(posedge clk); while (!s_axis_tready);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_hashes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== multi_column_key_hasher.f =====
+incdir+hdl
hdl/mckh_pkg.sv
hdl/mckh_mul.sv
hdl/multi_column_key_hasher.sv
verif/tb_multi_column_key_hasher.sv
